>>> sv/circular_deque_palindrome_unit_defines.svh
// Assertion macros for the circular deque palindrome unit.
// Used by the top level; depends on clk and rst_n in the including scope.
`ifndef CIRCULAR_DEQUE_PALINDROME_UNIT_DEFINES_SVH
`define CIRCULAR_DEQUE_PALINDROME_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset
`define CDP_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset
`define CDP_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define CDP_ASSERT_CLK(lbl, prop, msg)
`define CDP_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

>>> sv/cdp_pkg.sv
// Shared constants, types and pointer helpers for the circular deque unit.
// No dependencies; used by the interfaces, the storage and the top level.
package cdp_pkg;

  localparam int DEPTH  = 128;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [7:0]        byte_t;

  localparam addr_t LAST_IDX = addr_t'(DEPTH - 1);

  // Operation codes
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_REAR   = 3'd3;
  localparam logic [2:0] OP_CHECK      = 3'd4;

  // Status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_CHK
  } state_t;

  // Storage write and read request
  typedef struct packed {
    logic  we;
    addr_t waddr;
    byte_t wdata;
    addr_t raddr_a;
    addr_t raddr_b;
  } mem_req_t;

  function automatic addr_t wrap_next(addr_t i);
    return (i == LAST_IDX) ? '0 : addr_t'(i + 1'b1);
  endfunction

  function automatic addr_t wrap_prev(addr_t i);
    return (i == '0) ? LAST_IDX : addr_t'(i - 1'b1);
  endfunction

endpackage

>>> sv/cdp_in_if.sv
// Input channel of the deque unit: operation code and byte to push.
// Depends on cdp_pkg.
interface cdp_in_if import cdp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  byte_t      item;

  modport source (output valid, output operation, output item, input ready);
  modport sink   (input valid, input operation, input item, output ready);
endinterface

>>> sv/cdp_out_if.sv
// Result channel of the deque unit: popped byte, status and deque flags.
// Depends on cdp_pkg.
interface cdp_out_if import cdp_pkg::*; ();
  logic       valid;
  logic       ready;
  byte_t      item_out;
  logic [1:0] status;
  logic       is_palindrome;
  logic       is_full;
  logic       is_empty;

  modport source (output valid, output item_out, output status, output is_palindrome,
                  output is_full, output is_empty, input ready);
  modport sink   (input valid, input item_out, input status, input is_palindrome,
                  input is_full, input is_empty, output ready);
endinterface

>>> sv/cdp_mem.sv
// Deque byte storage: one write port, two registered read ports.
// Depends on cdp_pkg.
module cdp_mem import cdp_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output byte_t    rd_a,
  output byte_t    rd_b
);

  byte_t mem [DEPTH];
  byte_t rd_a_r;
  byte_t rd_b_r;

  // Write and read, read data registered for the next cycle
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_a_r <= mem[req.raddr_a];
    rd_b_r <= mem[req.raddr_b];
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

>>> sv/circular_deque_palindrome_unit.sv
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    operation[2:0], item[7:0]
// out_ch    out  valid/ready    item_out[7:0], status[1:0], is_palindrome, is_full, is_empty
//
// Push and unused codes: result registered at the accept edge.
// Pop: the storage read is registered, then ST_POP loads the byte; when empty, at the accept edge.
// Check: ST_CHK pops one pair per storage read (up to DEPTH/2 pairs).
// Reset (rst_n low, synchronous) empties the deque; storage is not cleared.
// No new item is taken while a result waits unaccepted or a pop or check is in flight.
//
// Top level of the circular deque palindrome unit; uses cdp_pkg, cdp_in_if,
// cdp_out_if, cdp_mem and the assertion macros header.
`include "circular_deque_palindrome_unit_defines.svh"

module circular_deque_palindrome_unit import cdp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  cdp_in_if.sink    in_ch,
  cdp_out_if.source out_ch
);

  state_t     state_r, state_nxt;
  addr_t      head_r, head_nxt;
  addr_t      tail_r, tail_nxt;
  logic       empty_r, empty_nxt;
  logic       out_valid_r, out_valid_nxt;
  byte_t      out_item_r, out_item_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic       out_pal_r, out_pal_nxt;
  logic       out_full_r, out_full_nxt;
  logic       out_empty_r, out_empty_nxt;

  mem_req_t   mem_req;
  byte_t      rd_a;
  byte_t      rd_b;

  logic       in_ready;
  logic       in_accept;
  logic       full_now;
  logic       multi_now;
  logic       pair_match;
  logic       pair_last;
  logic       chk_more;
  logic       load;
  byte_t      res_item;
  logic [1:0] res_status;
  logic       res_pal;

  cdp_mem u_mem (
    .clk  (clk),
    .req  (mem_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  // Handshake and deque conditions
  assign in_ready   = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_accept  = in_ch.valid && in_ready;
  assign full_now   = !empty_r && (wrap_next(tail_r) == head_r);
  assign multi_now  = !empty_r && (head_r != tail_r);
  assign pair_match = (rd_a == rd_b);
  assign pair_last  = (wrap_next(head_r) == tail_r);
  assign chk_more   = pair_match && !pair_last && (wrap_next(head_r) != wrap_prev(tail_r));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if ((in_ch.operation == OP_POP_FRONT || in_ch.operation == OP_POP_REAR) &&
              !empty_r) begin
            state_nxt = ST_POP;
          end else if (in_ch.operation == OP_CHECK && multi_now) begin
            state_nxt = ST_CHK;
          end
        end
      end
      ST_POP: begin
        state_nxt = ST_IDLE;
      end
      ST_CHK: begin
        if (!chk_more) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Pointer updates, storage access and result
  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    empty_nxt       = empty_r;
    load            = 1'b0;
    res_item        = '0;
    res_status      = STAT_DONE;
    res_pal         = 1'b0;
    mem_req.we      = 1'b0;
    mem_req.waddr   = head_r;
    mem_req.wdata   = in_ch.item;
    mem_req.raddr_a = head_r;
    mem_req.raddr_b = tail_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_ch.operation)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
              load = 1'b1;
              if (full_now) begin
                res_status = STAT_FULL;
              end else if (empty_r) begin
                head_nxt      = '0;
                tail_nxt      = '0;
                empty_nxt     = 1'b0;
                mem_req.we    = 1'b1;
                mem_req.waddr = '0;
              end else if (in_ch.operation == OP_PUSH_FRONT) begin
                head_nxt      = wrap_prev(head_r);
                mem_req.we    = 1'b1;
                mem_req.waddr = wrap_prev(head_r);
              end else begin
                tail_nxt      = wrap_next(tail_r);
                mem_req.we    = 1'b1;
                mem_req.waddr = wrap_next(tail_r);
              end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
              if (empty_r) begin
                load       = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                // Read the leaving entry; ST_POP loads the byte into the output register
                mem_req.raddr_a = (in_ch.operation == OP_POP_FRONT) ? head_r : tail_r;
                if (head_r == tail_r) begin
                  head_nxt  = '0;
                  tail_nxt  = '0;
                  empty_nxt = 1'b1;
                end else if (in_ch.operation == OP_POP_FRONT) begin
                  head_nxt = wrap_next(head_r);
                end else begin
                  tail_nxt = wrap_prev(tail_r);
                end
              end
            end
            OP_CHECK: begin
              // Fewer than two entries: nothing to pop
              if (!multi_now) begin
                load    = 1'b1;
                res_pal = 1'b1;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        load     = 1'b1;
        res_item = rd_a;
      end
      ST_CHK: begin
        // Drop the pair at both ends, then fetch the next pair
        if (pair_last) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          empty_nxt = 1'b1;
        end else begin
          head_nxt = wrap_next(head_r);
          tail_nxt = wrap_prev(tail_r);
        end
        mem_req.raddr_a = wrap_next(head_r);
        mem_req.raddr_b = wrap_prev(tail_r);
        if (!chk_more) begin
          load    = 1'b1;
          res_pal = pair_match;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // Output register: load a result or drain when taken
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_item_nxt   = out_item_r;
    out_status_nxt = out_status_r;
    out_pal_nxt    = out_pal_r;
    out_full_nxt   = out_full_r;
    out_empty_nxt  = out_empty_r;
    if (load) begin
      out_valid_nxt  = 1'b1;
      out_item_nxt   = res_item;
      out_status_nxt = res_status;
      out_pal_nxt    = res_pal;
      out_full_nxt   = !empty_nxt && (wrap_next(tail_nxt) == head_nxt);
      out_empty_nxt  = empty_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_item_r   <= out_item_nxt;
    out_status_r <= out_status_nxt;
    out_pal_r    <= out_pal_nxt;
    out_full_r   <= out_full_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.item_out      = out_item_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.is_palindrome = out_pal_r;
  assign out_ch.is_full       = out_full_r;
  assign out_ch.is_empty      = out_empty_r;

  // Checks
  `CDP_ASSERT_CLK(a_empty_ptrs_zero, empty_r |-> (head_r == '0 && tail_r == '0), "empty deque with nonzero pointers")
  `CDP_ASSERT_NEVER(a_busy_no_result, state_r != ST_IDLE && out_valid_r, "result pending during pop or check")
  `CDP_ASSERT_CLK(a_chk_has_pair, state_r == ST_CHK |-> (!empty_r && head_r != tail_r), "check step without a pair")
  `CDP_ASSERT_CLK(a_pop_gives_result, state_r == ST_POP |=> out_valid_r, "pop result not loaded")

endmodule
